[src/nidp_pkg.sv]
// Shared constants, types and cell interface for the nearly-isotonic L1 unit.
package nidp_pkg;

    localparam int MaxPoints  = 64;
    localparam int StoreDepth = MaxPoints + 1;
    localparam int ClipDepth  = MaxPoints - 1;
    localparam int CntW       = $clog2(StoreDepth + 1);
    localparam int ClipAw     = $clog2(ClipDepth);
    localparam int WtW        = 27;

    localparam logic [31:0] ValPosInf = 32'h7FFF_FFFF;
    localparam logic [31:0] ValNegInf = 32'h8000_0000;
    localparam logic [23:0] PenInf    = 24'hFF_FFFF;

    typedef logic signed [31:0] t_pos;
    typedef logic signed [WtW-1:0] t_wt;

    // Store operations broadcast to every cell.
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_INS  = 2'd1,
        OP_POPL = 2'd2
    } t_op;

    // Command from the controller to the row of cells.
    typedef struct packed {
        t_op  op;
        t_pos pos;
        t_wt  wt;
    } t_cmd;

endpackage

[src/nidp_cell.sv]
// One slot of the sorted breakpoint row; shifts with its neighbors on insert and pop.
module nidp_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  nidp_pkg::t_cmd i_cmd,
    input  logic           i_clr,
    input  logic           i_drop_top,
    input  logic           i_has_eq,
    input  logic           i_left_valid,
    input  logic           i_left_lt,
    input  nidp_pkg::t_pos i_left_pos,
    input  nidp_pkg::t_wt  i_left_wt,
    input  logic           i_right_valid,
    input  nidp_pkg::t_pos i_right_pos,
    input  nidp_pkg::t_wt  i_right_wt,
    input  logic           i_is_top,
    output logic           o_valid,
    output logic           o_lt,
    output nidp_pkg::t_pos o_pos,
    output nidp_pkg::t_wt  o_wt
);
    import nidp_pkg::*;

    logic r_valid;
    t_pos r_pos;
    t_wt  r_wt;
    logic n_valid;
    t_pos n_pos;
    t_wt  n_wt;
    logic w_lt;
    logic w_eq;

    assign w_lt  = r_valid && (r_pos < i_cmd.pos);
    assign w_eq  = r_valid && (r_pos == i_cmd.pos);
    assign o_valid = r_valid;
    assign o_lt    = w_lt;
    assign o_pos   = r_pos;
    assign o_wt    = r_wt;

    // Decide this slot's next content from its own compare and the left neighbor's.
    always_comb begin
        n_valid = r_valid;
        n_pos   = r_pos;
        n_wt    = r_wt;
        case (i_cmd.op)
            OP_INS: begin
                if (w_eq) begin
                    n_wt = r_wt + i_cmd.wt;
                end else if (!i_has_eq && !w_lt && i_left_lt && !i_is_top) begin
                    // insertion point: take the new entry, old one moves right
                    n_valid = 1'b1;
                    n_pos   = i_cmd.pos;
                    n_wt    = i_cmd.wt;
                end else if (!i_has_eq && !w_lt && !i_left_lt && i_left_valid &&
                             !i_is_top) begin
                    n_valid = 1'b1;
                    n_pos   = i_left_pos;
                    n_wt    = i_left_wt;
                end else if (!i_has_eq && !r_valid && i_left_lt && !i_is_top) begin
                    n_valid = 1'b1;
                    n_pos   = i_cmd.pos;
                    n_wt    = i_cmd.wt;
                end
            end
            OP_POPL: begin
                n_valid = i_right_valid;
                n_pos   = i_right_pos;
                n_wt    = i_right_wt;
            end
            default: begin
            end
        endcase
        if (i_drop_top) begin
            n_valid = 1'b0;
        end
    end

    // Hold slot contents; reset empties the slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_pos <= n_pos;
        r_wt  <= n_wt;
    end

endmodule

[src/nidp_row.sv]
// Row of breakpoint cells with insert, merge, pop-min and pop-max.
module nidp_row (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  nidp_pkg::t_cmd        i_cmd,
    input  logic                  i_clr,
    input  logic                  i_pop_max,
    input  logic [nidp_pkg::CntW-1:0] i_count,
    output nidp_pkg::t_pos        o_min_pos,
    output nidp_pkg::t_wt         o_min_wt,
    output nidp_pkg::t_pos        o_max_pos,
    output nidp_pkg::t_wt         o_max_wt,
    output logic                  o_has_eq
);
    import nidp_pkg::*;

    logic v   [StoreDepth+2];
    logic lt  [StoreDepth+1];
    t_pos pos [StoreDepth+2];
    t_wt  wt  [StoreDepth+2];
    logic [StoreDepth-1:0] eq_vec;
    logic [CntW-1:0] w_top;
    logic w_has_eq;

    assign w_top = i_count - CntW'(1);

    // Left boundary: always "less", so slot 0 takes a new minimum.
    assign v[0]   = 1'b0;
    assign lt[0]  = 1'b1;
    assign pos[0] = '0;
    assign wt[0]  = '0;

    // Right boundary: an empty slot shifts into the last cell on pop.
    assign v[StoreDepth+1]   = 1'b0;
    assign pos[StoreDepth+1] = '0;
    assign wt[StoreDepth+1]  = '0;

    genvar g;
    generate
        for (g = 0; g < StoreDepth; g++) begin : g_cell
            logic drop;
            assign drop = i_pop_max && (CntW'(g) == w_top);
            assign eq_vec[g] = v[g+1] && (pos[g+1] == i_cmd.pos);
            nidp_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (i_cmd),
                .i_clr        (i_clr),
                .i_drop_top   (drop),
                .i_has_eq     (w_has_eq),
                .i_left_valid (v[g]),
                .i_left_lt    (lt[g]),
                .i_left_pos   (pos[g]),
                .i_left_wt    (wt[g]),
                .i_right_valid(v[g+2]),
                .i_right_pos  (pos[g+2]),
                .i_right_wt   (wt[g+2]),
                .i_is_top     (1'b0),
                .o_valid      (v[g+1]),
                .o_lt         (lt[g+1]),
                .o_pos        (pos[g+1]),
                .o_wt         (wt[g+1])
            );
        end
    endgenerate

    // A merge into an existing entry holds every other slot in place.
    assign w_has_eq  = |eq_vec;
    assign o_has_eq  = w_has_eq;
    assign o_min_pos = pos[1];
    assign o_min_wt  = wt[1];

    // Read the top entry at count minus one.
    always_comb begin
        o_max_pos = pos[1];
        o_max_wt  = wt[1];
        for (int k = 0; k < StoreDepth; k++) begin
            if (CntW'(k) == w_top) begin
                o_max_pos = pos[k+1];
                o_max_wt  = wt[k+1];
            end
        end
    end

endmodule

[src/nearly_isotonic_l1_dp_unit.sv]
// Top level: controller that drives the breakpoint row and back-substitutes.
// A non-final sample steps through insert, left check, right check and clip store; each
//   truncated end also pops breakpoints and puts the remainder back; next start after.
// A final sample inserts, pops the minimum side one per cycle, then sends one result
//   per cycle from the last position down to zero; results cannot be stalled.
// Reset (sync, active low) and each sequence end leave one zero entry.
module nearly_isotonic_l1_dp_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_sample_value,
    input  logic [15:0] i_sample_weight,
    input  logic [23:0] i_down_penalty,
    input  logic [23:0] i_up_penalty,
    input  logic        i_final_sample,
    output logic        o_valid,
    output logic [31:0] o_fitted_value,
    output logic [5:0]  o_position_index,
    output logic        o_last_result
);
    import nidp_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_INS, S_LCHK, S_LPOP, S_LPUT, S_RCHK, S_RPOP, S_RPUT,
        S_CLIP, S_FMIN, S_OUT
    } t_state;

    t_state r_state;
    t_cmd   n_cmd;
    logic   n_clr;
    logic   n_popmax;
    logic [CntW-1:0] r_cnt;
    t_wt    r_ls, r_rs, r_acc;
    t_pos   r_v, r_x, r_lo, r_hi, r_ppos;
    t_wt    r_w, r_dp, r_up;
    logic   r_dinf, r_uinf, r_fin;
    logic [ClipAw:0] r_samp;
    logic [5:0] r_i;
    t_pos   r_lo_mem [ClipDepth];
    t_pos   r_hi_mem [ClipDepth];
    t_pos   r_lo_rd, r_hi_rd;
    t_pos   w_minp, w_maxp;
    t_wt    w_minw, w_maxw;
    logic   w_eq;
    t_pos   w_v;
    t_pos   w_cx;
    logic   w_emit;

    nidp_row u_row (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (n_cmd),
        .i_clr    (n_clr),
        .i_pop_max(n_popmax),
        .i_count  (r_cnt),
        .o_min_pos(w_minp),
        .o_min_wt (w_minw),
        .o_max_pos(w_maxp),
        .o_max_wt (w_maxw),
        .o_has_eq (w_eq)
    );

    // Saturate the reserved value codes.
    always_comb begin
        w_v = t_pos'(i_sample_value);
        if (i_sample_value == ValNegInf) w_v = t_pos'(32'h8000_0001);
        if (i_sample_value == ValPosInf) w_v = t_pos'(32'h7FFF_FFFE);
    end

    assign busy = (r_state != S_IDLE);

    // Launch a result on each output cycle.
    assign w_emit = (r_state == S_OUT) ||
                    (r_state == S_FMIN && !(r_acc < 0 && r_cnt != '0));

    // Drive row commands from the state; empty the row once the minimizer is known.
    always_comb begin
        n_cmd    = '{op: OP_NONE, pos: r_ppos, wt: r_acc};
        n_clr    = w_emit;
        n_popmax = 1'b0;
        unique case (r_state)
            S_INIT: begin
                n_cmd = '{op: OP_INS, pos: '0, wt: '0};
            end
            S_INS: begin
                n_cmd = '{op: OP_INS, pos: r_v, wt: r_w <<< 1};
            end
            S_LPOP, S_FMIN: begin
                if (r_state == S_LPOP || (r_acc < 0 && r_cnt != '0)) begin
                    n_cmd.op = (r_cnt != '0) ? OP_POPL : OP_NONE;
                end
            end
            S_LPUT: begin
                n_cmd = '{op: OP_INS, pos: r_ppos, wt: r_acc + r_dp};
            end
            S_RPOP: begin
                n_popmax = (r_cnt != '0);
            end
            S_RPUT: begin
                n_cmd = '{op: OP_INS, pos: r_ppos, wt: r_up - r_acc};
            end
            default: begin
            end
        endcase
    end

    assign w_cx = (r_x > r_hi_rd) ? r_hi_rd : ((r_x < r_lo_rd) ? r_lo_rd : r_x);

    // Sequence the sample processing and output pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
            r_ls    <= '0;
            r_rs    <= '0;
            r_samp  <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_emit;
            unique case (r_state)
                S_INIT: begin
                    r_cnt   <= CntW'(1);
                    r_ls    <= '0;
                    r_rs    <= '0;
                    r_samp  <= '0;
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (start) begin
                        r_v     <= w_v;
                        r_w     <= t_wt'(i_sample_weight);
                        r_dp    <= t_wt'(i_down_penalty);
                        r_up    <= t_wt'(i_up_penalty);
                        r_dinf  <= (i_down_penalty == PenInf);
                        r_uinf  <= (i_up_penalty == PenInf);
                        r_fin   <= i_final_sample || (32'(r_samp) >= 32'(MaxPoints - 1));
                        r_state <= S_INS;
                    end
                end
                S_INS: begin
                    r_rs <= r_rs + r_w;
                    r_ls <= r_ls - r_w;
                    if (!w_eq && r_cnt < CntW'(StoreDepth)) r_cnt <= r_cnt + CntW'(1);
                    r_lo <= t_pos'(ValNegInf);
                    r_hi <= t_pos'(ValPosInf);
                    if (r_fin) begin
                        // start from the smallest position after this insert
                        r_acc   <= r_ls - r_w;
                        r_x     <= (r_cnt == '0 || r_v < w_minp) ? r_v : w_minp;
                        r_state <= S_FMIN;
                    end else begin
                        r_state <= S_LCHK;
                    end
                end
                S_LCHK: begin
                    r_acc  <= r_ls;
                    r_ppos <= '0;
                    r_state <= (!r_dinf && r_ls < -r_dp) ? S_LPOP : S_RCHK;
                end
                S_LPOP: begin
                    if (r_cnt != '0) begin
                        r_ppos <= w_minp;
                        r_acc  <= r_acc + w_minw;
                        r_cnt  <= r_cnt - CntW'(1);
                    end
                    if (r_cnt == '0 || r_acc + w_minw >= -r_dp) r_state <= S_LPUT;
                end
                S_LPUT: begin
                    if (!w_eq && r_cnt < CntW'(StoreDepth)) r_cnt <= r_cnt + CntW'(1);
                    r_ls    <= -r_dp;
                    r_lo    <= r_ppos;
                    r_state <= S_RCHK;
                end
                S_RCHK: begin
                    r_acc  <= r_rs;
                    r_ppos <= '0;
                    r_state <= (!r_uinf && r_rs > r_up) ? S_RPOP : S_CLIP;
                end
                S_RPOP: begin
                    if (r_cnt != '0) begin
                        r_ppos <= w_maxp;
                        r_acc  <= r_acc - w_maxw;
                        r_cnt  <= r_cnt - CntW'(1);
                    end
                    if (r_cnt == '0 || r_acc - w_maxw <= r_up) r_state <= S_RPUT;
                end
                S_RPUT: begin
                    if (!w_eq && r_cnt < CntW'(StoreDepth)) r_cnt <= r_cnt + CntW'(1);
                    r_rs    <= r_up;
                    r_hi    <= r_ppos;
                    r_state <= S_CLIP;
                end
                S_CLIP: begin
                    r_lo_mem[r_samp[ClipAw-1:0]] <= r_lo;
                    r_hi_mem[r_samp[ClipAw-1:0]] <= r_hi;
                    r_samp  <= r_samp + 1'b1;
                    r_state <= S_IDLE;
                end
                S_FMIN: begin
                    if (r_acc < 0 && r_cnt != '0) begin
                        r_x   <= w_minp;
                        r_acc <= r_acc + w_minw;
                        r_cnt <= r_cnt - CntW'(1);
                    end else begin
                        r_i     <= r_samp[5:0];
                        r_lo_rd <= r_lo_mem[r_samp[ClipAw-1:0] - 1'b1];
                        r_hi_rd <= r_hi_mem[r_samp[ClipAw-1:0] - 1'b1];
                        o_fitted_value   <= r_x;
                        o_position_index <= r_samp[5:0];
                        o_last_result    <= (r_samp == '0);
                        r_state <= (r_samp == '0) ? S_INIT : S_OUT;
                    end
                end
                S_OUT: begin
                    // Clip against this position's bounds, fetch the next pair.
                    r_x     <= w_cx;
                    r_i     <= r_i - 1'b1;
                    r_lo_rd <= r_lo_mem[r_i[ClipAw-1:0] - 2'd2];
                    r_hi_rd <= r_hi_mem[r_i[ClipAw-1:0] - 2'd2];
                    o_fitted_value   <= w_cx;
                    o_position_index <= r_i - 1'b1;
                    o_last_result    <= (r_i == 6'd1);
                    if (r_i == 6'd1) r_state <= S_INIT;
                end
                default: r_state <= S_INIT;
            endcase
        end
    end

endmodule

[tb/testbench.sv]
// Self-checking testbench for the nearly-isotonic L1 dynamic-programming unit.
`timescale 1ns / 1ps

module testbench;
    import nidp_pkg::*;

    localparam logic [23:0] PenOff = PenInf;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_sample_value;
    logic [15:0] i_sample_weight;
    logic [23:0] i_down_penalty;
    logic [23:0] i_up_penalty;
    logic        i_final_sample;
    logic        o_valid;
    logic [31:0] o_fitted_value;
    logic [5:0]  o_position_index;
    logic        o_last_result;

    typedef struct {
        logic [31:0] value;
        logic [15:0] weight;
        logic [23:0] dpen;
        logic [23:0] upen;
        logic        fin;
    } t_sample;

    typedef struct {
        logic [31:0] fit;
        logic [5:0]  idx;
        logic        last;
    } t_fit;

    // Predictor state: breakpoint store, slopes and clip bounds.
    longint   bp_pos[$];
    longint   bp_wt[$];
    longint   slope_lo;
    longint   slope_hi;
    longint   clip_lo[MaxPoints];
    longint   clip_hi[MaxPoints];
    int       held;

    t_fit     fits_due[$];
    t_sample  samples[$];
    int       n_err;
    int       n_fits;
    int       n_seq;
    bit       directed_fit;
    logic [31:0] directed_val;

    nearly_isotonic_l1_dp_unit DUT (.*);

    // Clock: 4 ns period.
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic void clear_fit_state();
        bp_pos = '{0};
        bp_wt = '{0};
        slope_lo = 0;
        slope_hi = 0;
        held = 0;
    endfunction

    function automatic void add_breakpoint(longint p, longint w);
        int k;
        k = 0;
        while (k < bp_pos.size() && bp_pos[k] < p) k++;
        if (k < bp_pos.size() && bp_pos[k] == p) begin
            bp_wt[k] += w;
            return;
        end
        if (bp_pos.size() >= StoreDepth) return;
        bp_pos.insert(k, p);
        bp_wt.insert(k, w);
    endfunction

    // Advance the fit by one sample; queue fitted values on the final one.
    function automatic void fit_sample(t_sample s);
        longint v, acc, p, lo, hi, x;
        bit     fin;
        int     n;
        v = longint'($signed(s.value));
        if (v < -64'sd2147483647) v = -64'sd2147483647;
        if (v > 64'sd2147483646) v = 64'sd2147483646;
        fin = s.fin || held >= MaxPoints - 1;
        add_breakpoint(v, 2 * longint'(s.weight));
        slope_hi += s.weight;
        slope_lo -= s.weight;
        if (!fin) begin
            lo = longint'($signed(ValNegInf));
            hi = longint'($signed(ValPosInf));
            if (s.dpen != PenOff && slope_lo < -longint'(s.dpen)) begin
                acc = slope_lo;
                p = 0;
                while (acc < -longint'(s.dpen) && bp_pos.size() > 0) begin
                    p = bp_pos.pop_front();
                    acc += bp_wt.pop_front();
                end
                add_breakpoint(p, acc + s.dpen);
                slope_lo = -longint'(s.dpen);
                lo = p;
            end
            if (s.upen != PenOff && slope_hi > longint'(s.upen)) begin
                acc = slope_hi;
                p = 0;
                while (acc > longint'(s.upen) && bp_pos.size() > 0) begin
                    p = bp_pos.pop_back();
                    acc -= bp_wt.pop_back();
                end
                add_breakpoint(p, longint'(s.upen) - acc);
                slope_hi = s.upen;
                hi = p;
            end
            clip_lo[held] = lo;
            clip_hi[held] = hi;
            held++;
            return;
        end
        n = held + 1;
        acc = slope_lo;
        x = bp_pos.size() > 0 ? bp_pos[0] : 0;
        while (acc < 0 && bp_pos.size() > 0) begin
            x = bp_pos.pop_front();
            acc += bp_wt.pop_front();
        end
        for (int i = n - 1; i >= 0; i--) begin
            if (i < n - 1) begin
                if (x > clip_hi[i]) x = clip_hi[i];
                else if (x < clip_lo[i]) x = clip_lo[i];
            end
            fits_due.push_back('{fit: x[31:0], idx: i[5:0], last: (i == 0)});
        end
        clear_fit_state();
    endfunction

    function automatic t_sample mk(logic [31:0] v, logic [15:0] w, logic [23:0] d,
                                   logic [23:0] u, logic f);
        return '{value: v, weight: w, dpen: d, upen: u, fin: f};
    endfunction

    function automatic logic [23:0] rand_pen();
        case ($urandom_range(0, 9))
            0:       return PenOff;
            1:       return 24'd0;
            2:       return 24'($urandom);
            default: return 24'($urandom_range(0, 2048));
        endcase
    endfunction

    function automatic logic [31:0] rand_value(int spread);
        case ($urandom_range(0, 19))
            0:       return ValNegInf;
            1:       return ValPosInf;
            2:       return $urandom;
            default: return $urandom_range(0, 2 * spread) - spread;
        endcase
    endfunction

    // Check each strobed result against the oldest expectation.
    always @(posedge i_clk) begin
        t_fit e;
        if (i_rst_n && o_valid) begin
            n_fits++;
            if (fits_due.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result idx=%0d val=%h",
                                          o_position_index, o_fitted_value);
            end else begin
                e = fits_due.pop_front();
                if (o_fitted_value !== e.fit || o_position_index !== e.idx ||
                    o_last_result !== e.last) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: exp val=%h idx=%0d last=%b got val=%h idx=%0d last=%b",
                                 e.fit, e.idx, e.last, o_fitted_value,
                                 o_position_index, o_last_result);
                end
            end
        end
    end

    // Drive one sample and hold it until accepted.
    task automatic send_sample(t_sample s, bit quiet);
        while (!quiet && $urandom_range(0, 99) < 15) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_sample_value <= s.value;
        i_sample_weight <= s.weight;
        i_down_penalty <= s.dpen;
        i_up_penalty <= s.upen;
        i_final_sample <= s.fin;
        fit_sample(s);
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int spread, len, total;
        bit quiet;
        n_err = 0;
        n_fits = 0;
        n_seq = 0;
        clear_fit_state();
        start = 1'b0;
        i_sample_value = '0;
        i_sample_weight = '0;
        i_down_penalty = '0;
        i_up_penalty = '0;
        i_final_sample = 1'b0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: saturation codes, zero weights, unbounded and zero
        // penalties and penalty clipping.
        samples = '{
            mk(32'h0001_0000, 16'h0100, 24'd0, 24'd0, 1'b1),
            mk(ValNegInf, 16'hFFFF, 24'd0, 24'd0, 1'b1),
            mk(ValPosInf, 16'hFFFF, 24'd0, 24'd0, 1'b1),
            mk(32'h0005_0000, 16'h0000, 24'd0, 24'd0, 1'b1),
            mk(32'h0003_0000, 16'h0100, PenOff, PenOff, 1'b0),
            mk(32'hFFFE_0000, 16'h0100, PenOff, PenOff, 1'b0),
            mk(32'h0003_0000, 16'h0200, PenOff, PenOff, 1'b1),
            mk(32'h0004_0000, 16'h0100, 24'd0, 24'd0, 1'b0),
            mk(32'h0001_0000, 16'h0100, 24'd0, 24'd0, 1'b1),
            mk(32'h0004_0000, 16'h0100, 24'h80, 24'h80, 1'b0),
            mk(32'h0001_0000, 16'hFFFF, 24'hFFFFFE, 24'h0, 1'b0),
            mk(ValPosInf, 16'h8000, 24'h0, 24'hFFFFFE, 1'b0),
            mk(32'h0000_0000, 16'h0000, 24'h0, 24'h0, 1'b0),
            mk(32'h0002_0000, 16'h0001, 24'h0, 24'h0, 1'b1)
        };
        // Exact values that follow at a glance: single samples, saturated codes,
        // and a zero weight that leaves the reset entry at zero as the minimizer.
        for (int r = 0; r < samples.size(); r++) begin
            directed_fit = r < 4;
            directed_val = r == 1 ? 32'h8000_0001 : r == 2 ? 32'h7FFF_FFFE :
                           r == 3 ? 32'h0000_0000 : samples[r].value;
            send_sample(samples[r], 1'b0);
            if (directed_fit && (fits_due.size() != 1 || fits_due[0].fit !== directed_val)) begin
                n_err++;
                if (n_err <= 10) $display("directed row %0d: expected %h", r, directed_val);
            end
        end
        // Overflow: 64 samples with the final bit never set.
        for (int k = 0; k < MaxPoints; k++)
            send_sample(mk($urandom, 16'($urandom), rand_pen(), rand_pen(), 1'b0), 1'b0);

        // Random sequences: mostly short, a few at full length.
        total = 0;
        while (total < 400) begin
            len = ($urandom_range(0, 9) == 0) ? MaxPoints : $urandom_range(1, 12);
            spread = $urandom_range(0, 3) == 0 ? 32'h0010_0000 : 32'h40;
            quiet = (total >= 150 && total < 230);
            for (int k = 0; k < len; k++)
                send_sample(mk(rand_value(spread), $urandom_range(0, 3) == 0 ?
                               16'($urandom) : 16'($urandom_range(0, 512)),
                               rand_pen(), rand_pen(), k == len - 1), quiet);
            total += len;
            n_seq++;
        end
        start <= 1'b0;

        while (fits_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Covered %0d random sequences plus directed rows; %0d fitted values checked.",
                 n_seq, n_fits);
        if (n_err == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", n_err);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
